@@ rtl/tta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_pkg
// Shared types and constants of the texture tap address unit.
// ----------------------------------------------------------------------------
package tta_pkg;

	localparam int FP_W       = 32;
	localparam int EXP_W      = 8;
	localparam int MAN_W      = 23;
	localparam int SIG_W      = 24;
	localparam int SIZE_W     = 15;
	localparam int TAP_W      = 14;
	localparam int BLEND_W    = 16;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 3;

	localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'd255;
	localparam logic [EXP_W-1:0] EXP_ONE      = 8'd127;
	localparam logic [EXP_W-1:0] EXP_INT      = 8'd150;
	localparam logic [EXP_W-1:0] SUBN_SHIFT   = 8'd149;

	localparam int SIZE_LIMIT = (1 << SIZE_W) - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEX_WIDTH     = 3'd0,
		CFG_TEX_HEIGHT    = 3'd1,
		CFG_WRAP_U        = 3'd2,
		CFG_WRAP_V        = 3'd3,
		CFG_FILTER_LINEAR = 3'd4
	} cfg_reg_t;

	// Load enables of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_adv_t;

	// Addressing set-up of one axis
	typedef struct packed {
		logic              wrap;
		logic              linear;
		logic [SIZE_W-1:0] size;
	} axis_cfg_t;

endpackage

@@ rtl/texture_tap_address_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_tap_address_unit
// Texel tap addresses and bilinear weights from a binary32 (u, v) pair.
// ----------------------------------------------------------------------------
// Takes one (u, v) coordinate transfer per clock while the output is not
// stalled and carries it through the pipeline stages to the output ports:
// stage 1 decodes the float and shifts it into fixed point, stage 2
// finishes the clamp or repeat reduction, stage 3 multiplies by the texture
// size, stage 4 forms the taps and weights and holds the result on the
// output ports. Throughput is one item per cycle while out_ready stays high:
// every stage can load in each cycle, and the single size multiplier per
// axis sits alone in stage 3. Each stage moves on
// when it is empty or the stage after it moves, so a stalled output only
// holds up as many stages as are full; bubbles are squeezed out. Write the
// configuration registers only while no item is in flight. Sizes of 0 act
// as 1 and sizes above MAX_DIM act as MAX_DIM; tap indices are 14 bits.
// ----------------------------------------------------------------------------
module texture_tap_address_unit
	import tta_pkg::*;
#(
	parameter int MAX_DIM         = 16384,
	parameter int COORD_FRAC_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FP_W-1:0]       coord_u,
	input  logic [FP_W-1:0]       coord_v,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TAP_W-1:0]      u_first,
	output logic [TAP_W-1:0]      u_second,
	output logic [TAP_W-1:0]      v_first,
	output logic [TAP_W-1:0]      v_second,
	output logic [BLEND_W-1:0]    u_blend,
	output logic [BLEND_W-1:0]    v_blend
);

	localparam int F  = COORD_FRAC_BITS;
	localparam int PW = F + SIZE_W + 1;
	localparam logic [SIZE_W-1:0] DIM_CAP =
		SIZE_W'((MAX_DIM > SIZE_LIMIT) ? SIZE_LIMIT : MAX_DIM);

	// Configuration; sizes are kept already limited to the legal range
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              wrap_u_q;
	logic              wrap_v_q;
	logic              linear_q;
	logic [SIZE_W-1:0] size_in;

	axis_cfg_t cfg_u;
	axis_cfg_t cfg_v;

	// Pipeline occupancy and flow control
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       valid_s4;
	stage_adv_t adv;

	logic [F:0]  r_u_s2;
	logic [F:0]  r_v_s2;
	logic [PW-1:0] p_u_s3;
	logic [PW-1:0] p_v_s3;

	// Clamp a written size to 1 .. MAX_DIM
	always_comb begin
		if (cfg_data[SIZE_W-1:0] == '0) begin
			size_in = SIZE_W'(1);
		end else if (cfg_data[SIZE_W-1:0] > DIM_CAP) begin
			size_in = DIM_CAP;
		end else begin
			size_in = cfg_data[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(1);
			height_q <= SIZE_W'(1);
			wrap_u_q <= 1'b0;
			wrap_v_q <= 1'b0;
			linear_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TEX_WIDTH:     width_q  <= size_in;
				CFG_TEX_HEIGHT:    height_q <= size_in;
				CFG_WRAP_U:        wrap_u_q <= cfg_data[0];
				CFG_WRAP_V:        wrap_v_q <= cfg_data[0];
				CFG_FILTER_LINEAR: linear_q <= cfg_data[0];
				default: ; // drop writes past the register list
			endcase
		end
	end

	assign cfg_u = '{wrap: wrap_u_q, linear: linear_q, size: width_q};
	assign cfg_v = '{wrap: wrap_v_q, linear: linear_q, size: height_q};

	// A stage loads when it is empty or its contents move on downstream
	assign adv.s4 = !valid_s4 || out_ready;
	assign adv.s3 = !valid_s3 || adv.s4;
	assign adv.s2 = !valid_s2 || adv.s3;
	assign adv.s1 = !valid_s1 || adv.s2;

	assign in_ready  = adv.s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv.s1) begin
				valid_s1 <= in_valid;
			end
			if (adv.s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv.s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stages 1 and 2: reduce each coordinate to [0,1]
	tta_reduce #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_reduce_u (
		.clk   (clk),
		.adv   (adv),
		.cfg   (cfg_u),
		.coord (coord_u),
		.r_s2  (r_u_s2)
	);

	tta_reduce #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_reduce_v (
		.clk   (clk),
		.adv   (adv),
		.cfg   (cfg_v),
		.coord (coord_v),
		.r_s2  (r_v_s2)
	);

	// Stage 3: scale by texture size
	tta_scale #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_scale_u (
		.clk  (clk),
		.adv  (adv),
		.cfg  (cfg_u),
		.r_s2 (r_u_s2),
		.p_s3 (p_u_s3)
	);

	tta_scale #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_scale_v (
		.clk  (clk),
		.adv  (adv),
		.cfg  (cfg_v),
		.r_s2 (r_v_s2),
		.p_s3 (p_v_s3)
	);

	// Stage 4: taps and weights, held on the output ports
	tta_tap #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_tap_u (
		.clk       (clk),
		.adv       (adv),
		.cfg       (cfg_u),
		.p_s3      (p_u_s3),
		.first_s4  (u_first),
		.second_s4 (u_second),
		.blend_s4  (u_blend)
	);

	tta_tap #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_tap_v (
		.clk       (clk),
		.adv       (adv),
		.cfg       (cfg_v),
		.p_s3      (p_v_s3),
		.first_s4  (v_first),
		.second_s4 (v_second),
		.blend_s4  (v_blend)
	);

endmodule

@@ rtl/tta_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_reduce
// Binary32 coordinate to fixed-point r in [0,1]: clamp or fractional part.
// ----------------------------------------------------------------------------
module tta_reduce
	import tta_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 32
) (
	input  logic                     clk,
	input  stage_adv_t               adv,
	input  axis_cfg_t                cfg,
	input  logic [FP_W-1:0]          coord,
	output logic [COORD_FRAC_BITS:0] r_s2
);

	localparam int F  = COORD_FRAC_BITS;
	localparam int SW = SIG_W + F;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	logic [EXP_W-1:0] expo;
	logic [MAN_W-1:0] man;
	logic             neg;
	logic [SIG_W-1:0] sig;
	logic [EXP_W-1:0] shamt;
	logic [SIG_W-1:0] fnum;
	logic [SW-1:0]    wide;
	logic [SW-1:0]    shifted;
	logic             rem_nz;
	logic             kill;

	logic             kill_s1;
	logic             big_s1;
	logic             neg_s1;
	logic             rem_s1;
	logic [F-1:0]     frac_s1;

	logic [F:0]       r_next;

	assign expo = coord[FP_W-2 -: EXP_W];
	assign man  = coord[MAN_W-1:0];
	assign neg  = coord[FP_W-1];
	assign sig  = (expo == '0) ? {1'b0, man} : {1'b1, man};

	// Right shift that turns sig * 2^F into the fixed-point value
	assign shamt = (expo == '0) ? SUBN_SHIFT : EXP_INT - expo;

	// Integer bits drop out; for a value below one, as clamp mode uses, the shift is 24 or more
	assign fnum    = sig & ~({SIG_W{1'b1}} << shamt);
	assign wide    = {fnum, {F{1'b0}}};
	assign shifted = wide >> shamt;
	assign rem_nz  = |(wide & ~({SW{1'b1}} << shamt));

	assign kill = (expo == EXP_ALL_ONES) || (sig == '0) ||
		(cfg.wrap ? ((expo >= EXP_INT) || (fnum == '0)) : neg);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			kill_s1 <= kill;
			big_s1  <= (expo >= EXP_ONE);
			neg_s1  <= neg;
			rem_s1  <= rem_nz;
			frac_s1 <= shifted[F-1:0];
		end
	end

	always_comb begin
		if (kill_s1) begin
			r_next = '0;
		end else if (!cfg.wrap) begin
			r_next = big_s1 ? ONE : {1'b0, frac_s1};
		end else if (neg_s1) begin
			// fraction of a negative value: one minus the rounded-up magnitude
			r_next = ONE - ({1'b0, frac_s1} + (F+1)'(rem_s1));
		end else begin
			r_next = {1'b0, frac_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			r_s2 <= r_next;
		end
	end

endmodule

@@ rtl/tta_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_scale
// Scale the reduced coordinate by the texture size of its axis.
// ----------------------------------------------------------------------------
module tta_scale
	import tta_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 32
) (
	input  logic                              clk,
	input  stage_adv_t                        adv,
	input  axis_cfg_t                         cfg,
	input  logic [COORD_FRAC_BITS:0]          r_s2,
	output logic [COORD_FRAC_BITS+SIZE_W:0]   p_s3
);

	localparam int PW = COORD_FRAC_BITS + SIZE_W + 1;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			p_s3 <= PW'(r_s2) * PW'(cfg.size);
		end
	end

endmodule

@@ rtl/tta_tap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_tap
// Tap indices and blend weight of one axis from the scaled coordinate.
// ----------------------------------------------------------------------------
module tta_tap
	import tta_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 32
) (
	input  logic                            clk,
	input  stage_adv_t                      adv,
	input  axis_cfg_t                       cfg,
	input  logic [COORD_FRAC_BITS+SIZE_W:0] p_s3,
	output logic [TAP_W-1:0]                first_s4,
	output logic [TAP_W-1:0]                second_s4,
	output logic [BLEND_W-1:0]              blend_s4
);

	localparam int F  = COORD_FRAC_BITS;
	localparam int PW = F + SIZE_W + 1;
	localparam int IW = SIZE_W + 1;
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

	logic [IW-1:0] size_x;
	logic [IW-1:0] near_tap;
	logic          below;
	logic [PW-1:0] q;
	logic [PW-1:0] w;
	logic [IW-1:0] t;
	logic [IW-1:0] first_n;
	logic [IW-1:0] second_n;
	logic [BLEND_W-1:0] blend_n;

	// Fold an index at or past the edge back into the texture
	function automatic logic [IW-1:0] fit_tap(
		input logic [IW-1:0] tap,
		input logic [IW-1:0] size,
		input logic          wrap
	);
		logic [IW-1:0] res;
		if (tap < size) begin
			res = tap;
		end else if (wrap) begin
			res = tap - size;
		end else begin
			res = size - IW'(1);
		end
		return res;
	endfunction

	assign size_x   = {1'b0, cfg.size};
	assign near_tap = p_s3[F +: IW];
	assign below    = (p_s3 < HALF);
	assign q        = p_s3 - HALF;
	assign t        = q[F +: IW];
	assign w        = below ? (p_s3 + HALF) : q;

	always_comb begin
		if (!cfg.linear) begin
			first_n  = fit_tap(near_tap, size_x, cfg.wrap);
			second_n = first_n;
			blend_n  = '0;
		end else if (below) begin
			first_n  = cfg.wrap ? (size_x - IW'(1)) : '0;
			second_n = '0;
			blend_n  = w[F-1 -: BLEND_W];
		end else begin
			first_n  = fit_tap(t, size_x, cfg.wrap);
			second_n = fit_tap(t + IW'(1), size_x, cfg.wrap);
			blend_n  = w[F-1 -: BLEND_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			first_s4  <= first_n[TAP_W-1:0];
			second_s4 <= second_n[TAP_W-1:0];
			blend_s4  <= blend_n;
		end
	end

endmodule
